// File: rtl/send_on_delta_trigger_macros.svh
// assertion macros for the send-on-delta trigger
`ifndef SEND_ON_DELTA_TRIGGER_MACROS_SVH
`define SEND_ON_DELTA_TRIGGER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SOD_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("sod check failed");

// next-cycle implication, disabled while reset is low
`define SOD_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("sod check failed");

`endif

// File: rtl/sod_pkg.sv
package sod_pkg;

    localparam int DEFAULT_STATE_COUNT = 8;
    localparam int DEFAULT_SAMPLE_BITS = 16;
    localparam int DEFAULT_TIME_BITS   = 32;

    localparam int IDX_BITS    = 3;
    localparam int DELTA_W     = 19;
    localparam int KIND_W      = 2;
    localparam int GAP_W       = 32;
    localparam int NORM_W      = 35;
    localparam int COUNT_W     = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [NORM_W-1:0]  NORM_CAP  = '1;
    localparam logic [COUNT_W-1:0] COUNT_CAP = '1;

    localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(256);
    localparam logic [KIND_W-1:0]  KIND_RESET  = '0;
    localparam logic [GAP_W-1:0]   GAP_RESET   = GAP_W'(1000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP   = 2'd2;

    // norm kinds, anything else acts as chebyshev
    localparam logic [KIND_W-1:0] NORM_CHEB = 2'd0;
    localparam logic [KIND_W-1:0] NORM_L1   = 2'd1;
    localparam logic [KIND_W-1:0] NORM_L2   = 2'd2;

    typedef struct packed {
        logic last;
        logic force_req;
        logic in_range;
    } t_item_ctl;

    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [KIND_W-1:0]  kind;
        logic [GAP_W-1:0]   gap;
    } t_cfg;

endpackage

// File: rtl/sod_in_if.sv
interface sod_in_if #(
    parameter int SAMPLE_BITS = sod_pkg::DEFAULT_SAMPLE_BITS,
    parameter int TIME_BITS   = sod_pkg::DEFAULT_TIME_BITS
);
    import sod_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [IDX_BITS-1:0]           element_index;
    logic                          last_element;
    logic [TIME_BITS-1:0]          timestamp;
    logic                          force_req;

    modport source (
        output valid, sample, element_index, last_element, timestamp, force_req,
        input  ready
    );
    modport sink (
        input  valid, sample, element_index, last_element, timestamp, force_req,
        output ready
    );
endinterface

// File: rtl/sod_out_if.sv
interface sod_out_if;
    import sod_pkg::*;

    logic               valid;
    logic               ready;
    logic               transmit;
    logic               was_forced;
    logic [NORM_W-1:0]  norm_level;
    logic [COUNT_W-1:0] sent_count;
    logic [COUNT_W-1:0] held_count;

    modport source (
        output valid, transmit, was_forced, norm_level, sent_count, held_count,
        input  ready
    );
    modport sink (
        input  valid, transmit, was_forced, norm_level, sent_count, held_count,
        output ready
    );
endinterface

// File: rtl/sod_front.sv
module sod_front #(
    parameter int STATE_COUNT = sod_pkg::DEFAULT_STATE_COUNT,
    parameter int SAMPLE_BITS = sod_pkg::DEFAULT_SAMPLE_BITS,
    parameter int TIME_BITS   = sod_pkg::DEFAULT_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sod_in_if.sink                         i_in,
    output logic                           o_q_valid,
    input  logic                           i_q_pop,
    output sod_pkg::t_item_ctl             o_q_ctl,
    output logic signed [SAMPLE_BITS-1:0]  o_q_sample,
    output logic [sod_pkg::IDX_BITS-1:0]   o_q_idx,
    output logic [TIME_BITS-1:0]           o_q_time
);
    import sod_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    t_item_ctl                   r_q_ctl    [QUEUE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_q_sample [QUEUE_DEPTH];
    logic [IDX_BITS-1:0]         r_q_idx    [QUEUE_DEPTH];
    logic [TIME_BITS-1:0]        r_q_time   [QUEUE_DEPTH];

    logic [QP_W-1:0] r_wr, r_rd;
    logic [QP_W:0]   r_count, n_count;
    logic            w_push, w_pop;
    t_item_ctl       w_ctl;

    assign i_in.ready = (r_count != (QP_W+1)'(QUEUE_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_q_pop && o_q_valid;

    // classify: out-of-range components only count for their last marker
    always_comb begin
        w_ctl.last      = i_in.last_element;
        w_ctl.force_req = i_in.force_req;
        w_ctl.in_range  = (32'(i_in.element_index) < STATE_COUNT);
    end

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_ctl[r_wr]    <= w_ctl;
            r_q_sample[r_wr] <= i_in.sample;
            r_q_idx[r_wr]    <= i_in.element_index;
            r_q_time[r_wr]   <= i_in.timestamp;
        end
    end

    assign o_q_valid  = (r_count != '0);
    assign o_q_ctl    = r_q_ctl[r_rd];
    assign o_q_sample = r_q_sample[r_rd];
    assign o_q_idx    = r_q_idx[r_rd];
    assign o_q_time   = r_q_time[r_rd];

endmodule

// File: rtl/sod_back.sv
module sod_back #(
    parameter int STATE_COUNT = sod_pkg::DEFAULT_STATE_COUNT,
    parameter int SAMPLE_BITS = sod_pkg::DEFAULT_SAMPLE_BITS,
    parameter int TIME_BITS   = sod_pkg::DEFAULT_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sod_pkg::t_cfg                  i_cfg,
    input  logic                           i_q_valid,
    output logic                           o_q_pop,
    input  sod_pkg::t_item_ctl             i_q_ctl,
    input  logic signed [SAMPLE_BITS-1:0]  i_q_sample,
    input  logic [sod_pkg::IDX_BITS-1:0]   i_q_idx,
    input  logic [TIME_BITS-1:0]           i_q_time,
    sod_out_if.source                      o_out
);
    import sod_pkg::*;

    localparam int IDX_W  = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int MAG_W  = SAMPLE_BITS + 1;
    localparam int TERM_W = 2 * MAG_W;
    localparam int SUM_W  = ((TERM_W > NORM_W) ? TERM_W : NORM_W) + 1;
    localparam int LIM_W  = 2 * DELTA_W;
    localparam int GCMP_W = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;

    // reference and pending vectors
    logic signed [SAMPLE_BITS-1:0] r_ref  [STATE_COUNT];
    logic signed [SAMPLE_BITS-1:0] r_pend [STATE_COUNT];
    logic signed [SAMPLE_BITS-1:0] n_pend [STATE_COUNT];
    logic [STATE_COUNT-1:0]        r_mask, n_mask;

    logic [NORM_W-1:0]    r_acc, r_held, n_acc;
    logic [TIME_BITS-1:0] r_last_time;
    logic                 r_have_sent;
    logic [COUNT_W-1:0]   r_sent, r_held_cnt, n_sent, n_held_cnt;
    logic [LIM_W-1:0]     r_limit_sq;

    // stage 1: difference and square
    logic                          r_s1_v;
    t_item_ctl                     r_s1_ctl;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic [IDX_W-1:0]              r_s1_idx;
    logic [TIME_BITS-1:0]          r_s1_time;

    // stage 2: fold and decide
    logic                          r_s2_v;
    t_item_ctl                     r_s2_ctl;
    logic signed [SAMPLE_BITS-1:0] r_s2_sample;
    logic [IDX_W-1:0]              r_s2_idx;
    logic [TIME_BITS-1:0]          r_s2_time;
    logic [MAG_W-1:0]              r_s2_mag;
    logic [TERM_W-1:0]             r_s2_sq;

    logic                 r_out_v;
    logic                 r_out_tx, r_out_forced;
    logic [NORM_W-1:0]    r_out_norm;
    logic [COUNT_W-1:0]   r_out_sent, r_out_held;

    logic                          w_out_free, w_s2_go, w_s1_go;
    logic signed [SAMPLE_BITS-1:0] w_ref;
    logic signed [MAG_W-1:0]       w_diff;
    logic [MAG_W-1:0]              w_mag;
    logic [TERM_W-1:0]             w_sq;
    logic [SUM_W-1:0]              w_sum;
    logic [TIME_BITS-1:0]          w_elapsed;
    logic                          w_gap_hit, w_eval, w_send;
    logic [LIM_W-1:0]              w_limit;

    assign w_out_free = !r_out_v || o_out.ready;
    assign w_s2_go    = r_s2_v && (!r_s2_ctl.last || w_out_free);
    // a component behind a decision waits in stage 1 until the decision has left stage 2 and updated the reference
    assign w_s1_go    = r_s1_v && (!r_s2_v || (w_s2_go && !r_s2_ctl.last));
    assign o_q_pop    = i_q_valid && (!r_s1_v || w_s1_go);

    // stage 1 datapath
    assign w_ref  = r_s1_ctl.in_range ? r_ref[r_s1_idx] : '0;
    assign w_diff = MAG_W'(r_s1_sample) - MAG_W'(w_ref);
    assign w_mag  = w_diff[MAG_W-1] ? MAG_W'(-w_diff) : MAG_W'(w_diff);
    assign w_sq   = TERM_W'(w_mag) * TERM_W'(w_mag);

    always_ff @(posedge i_clk) begin
        r_limit_sq <= LIM_W'(i_cfg.delta) * LIM_W'(i_cfg.delta);
    end

    // stage 2: fold the component into the running norm
    always_comb begin
        w_sum = '0;
        n_acc = r_acc;
        if (r_s2_ctl.in_range) begin
            case (i_cfg.kind)
                NORM_L1: begin
                    w_sum = SUM_W'(r_acc) + SUM_W'(r_s2_mag);
                    n_acc = (w_sum > SUM_W'(NORM_CAP)) ? NORM_CAP : NORM_W'(w_sum);
                end
                NORM_L2: begin
                    w_sum = SUM_W'(r_acc) + SUM_W'(r_s2_sq);
                    n_acc = (w_sum > SUM_W'(NORM_CAP)) ? NORM_CAP : NORM_W'(w_sum);
                end
                default: begin
                    w_sum = SUM_W'(r_s2_mag);
                    if (w_sum > SUM_W'(r_acc)) begin
                        n_acc = (w_sum > SUM_W'(NORM_CAP)) ? NORM_CAP : NORM_W'(w_sum);
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_mask = r_mask;
        for (int i = 0; i < STATE_COUNT; i++) begin
            n_pend[i] = r_pend[i];
            if (r_s2_ctl.in_range && (r_s2_idx == IDX_W'(i))) begin
                n_pend[i] = r_s2_sample;
                n_mask[i] = 1'b1;
            end
        end
    end

    // decision on the last component
    assign w_elapsed = r_s2_time - r_last_time;
    assign w_gap_hit = r_have_sent && (GCMP_W'(w_elapsed) < GCMP_W'(i_cfg.gap));
    assign w_eval    = !r_s2_ctl.force_req && !w_gap_hit;
    assign w_limit   = (i_cfg.kind == NORM_L2) ? r_limit_sq : LIM_W'(i_cfg.delta);
    assign w_send    = r_s2_ctl.force_req || (w_eval && (LIM_W'(n_acc) > w_limit));
    assign n_sent    = (w_send && (r_sent != COUNT_CAP)) ? r_sent + 1'b1 : r_sent;
    assign n_held_cnt = (!w_send && (r_held_cnt != COUNT_CAP)) ?
                        r_held_cnt + 1'b1 : r_held_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (w_s1_go) begin
                r_s2_v <= 1'b1;
            end else if (w_s2_go) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_ctl    <= i_q_ctl;
            r_s1_sample <= i_q_sample;
            r_s1_idx    <= IDX_W'(i_q_idx);
            r_s1_time   <= i_q_time;
        end
        if (w_s1_go) begin
            r_s2_ctl    <= r_s1_ctl;
            r_s2_sample <= r_s1_sample;
            r_s2_idx    <= r_s1_idx;
            r_s2_time   <= r_s1_time;
            r_s2_mag    <= w_mag;
            r_s2_sq     <= w_sq;
        end
        if (w_s2_go) begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STATE_COUNT; i++) begin
                r_ref[i] <= '0;
            end
            r_mask      <= '0;
            r_acc       <= '0;
            r_held      <= '0;
            r_last_time <= '0;
            r_have_sent <= 1'b0;
            r_sent      <= '0;
            r_held_cnt  <= '0;
        end else if (w_s2_go) begin
            if (!r_s2_ctl.last) begin
                r_acc  <= n_acc;
                r_mask <= n_mask;
            end else begin
                r_acc  <= '0;
                r_mask <= '0;
                if (w_eval) begin
                    r_held <= n_acc;
                end
                if (w_send) begin
                    for (int i = 0; i < STATE_COUNT; i++) begin
                        if (n_mask[i]) begin
                            r_ref[i] <= n_pend[i];
                        end
                    end
                    r_last_time <= r_s2_time;
                    r_have_sent <= 1'b1;
                end
                r_sent     <= n_sent;
                r_held_cnt <= n_held_cnt;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_s2_go && r_s2_ctl.last) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_go && r_s2_ctl.last) begin
            r_out_tx     <= w_send;
            r_out_forced <= r_s2_ctl.force_req;
            r_out_norm   <= w_eval ? n_acc : r_held;
            r_out_sent   <= n_sent;
            r_out_held   <= n_held_cnt;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.transmit   = r_out_tx;
    assign o_out.was_forced = r_out_forced;
    assign o_out.norm_level = r_out_norm;
    assign o_out.sent_count = r_out_sent;
    assign o_out.held_count = r_out_held;

endmodule

// File: rtl/send_on_delta_trigger.sv
// path: from input transfer to result valid through the queue, difference and decision stages into the result register
// throughput: one component per cycle unless a last component is held by a stalled result register; the next
// component waits in stage 1 until a decision has left stage 2, since it needs the updated reference vector
// reset: synchronous active-low i_rst_n clears the reference vector, norm, counters
// and config to reset values; no clearing pass
module send_on_delta_trigger #(
    parameter int STATE_COUNT = sod_pkg::DEFAULT_STATE_COUNT,
    parameter int SAMPLE_BITS = sod_pkg::DEFAULT_SAMPLE_BITS,
    parameter int TIME_BITS   = sod_pkg::DEFAULT_TIME_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sod_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sod_pkg::CFG_W-1:0]       i_cfg_data,
    sod_in_if.sink                          i_in,
    sod_out_if.source                       o_out
);
    import sod_pkg::*;

    t_cfg r_cfg;

    logic                          w_q_valid, w_q_pop;
    t_item_ctl                     w_q_ctl;
    logic signed [SAMPLE_BITS-1:0] w_q_sample;
    logic [IDX_BITS-1:0]           w_q_idx;
    logic [TIME_BITS-1:0]          w_q_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delta <= DELTA_RESET;
            r_cfg.kind  <= KIND_RESET;
            r_cfg.gap   <= GAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELTA: r_cfg.delta <= i_cfg_data[DELTA_W-1:0];
                CFG_KIND:  r_cfg.kind  <= i_cfg_data[KIND_W-1:0];
                CFG_GAP:   r_cfg.gap   <= i_cfg_data[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sod_front #(
        .STATE_COUNT(STATE_COUNT),
        .SAMPLE_BITS(SAMPLE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_ctl   (w_q_ctl),
        .o_q_sample(w_q_sample),
        .o_q_idx   (w_q_idx),
        .o_q_time  (w_q_time)
    );

    sod_back #(
        .STATE_COUNT(STATE_COUNT),
        .SAMPLE_BITS(SAMPLE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_ctl   (w_q_ctl),
        .i_q_sample(w_q_sample),
        .i_q_idx   (w_q_idx),
        .i_q_time  (w_q_time),
        .o_out     (o_out)
    );

endmodule

// File: rtl/sod_checker.sv
`include "send_on_delta_trigger_macros.svh"

module sod_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic                         i_transmit,
    input logic                         i_was_forced,
    input logic [sod_pkg::NORM_W-1:0]   i_norm_level,
    input logic [sod_pkg::COUNT_W-1:0]  i_sent_count,
    input logic [sod_pkg::COUNT_W-1:0]  i_held_count
);
    import sod_pkg::*;

    logic [NORM_W+2*COUNT_W+1:0] w_payload;

    assign w_payload = {i_transmit, i_was_forced, i_norm_level, i_sent_count, i_held_count};

    // a stalled result holds
    `SOD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(w_payload))
    // a forced result is always a send
    `SOD_ASSERT_IMP(a_forced_sends, i_clk, i_rst_n, i_valid && i_was_forced, i_transmit)
    // a send has been counted
    `SOD_ASSERT_IMP(a_sent_counted, i_clk, i_rst_n, i_valid && i_transmit, i_sent_count != '0)
    // a held vector has been counted
    `SOD_ASSERT_IMP(a_held_counted, i_clk, i_rst_n, i_valid && !i_transmit, i_held_count != '0)

endmodule

bind send_on_delta_trigger sod_checker u_sod_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_transmit  (o_out.transmit),
    .i_was_forced(o_out.was_forced),
    .i_norm_level(o_out.norm_level),
    .i_sent_count(o_out.sent_count),
    .i_held_count(o_out.held_count)
);

// File: verif/sod_tb_pkg.sv
`timescale 1ns / 1ps
package sod_tb_pkg;
    import sod_pkg::*;

    localparam int SAMPLE_W   = DEFAULT_SAMPLE_BITS;
    localparam int TIME_W     = DEFAULT_TIME_BITS;
    localparam int VEC_LEN    = DEFAULT_STATE_COUNT;
    localparam int REPORT_CAP = 100;

    // unused kind code, decodes like chebyshev
    localparam logic [KIND_W-1:0] NORM_SPARE = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_BITS-1:0]        element_index;
        logic                       last_element;
        logic [TIME_W-1:0]          timestamp;
        logic                       force_req;
    } sod_comp_t;

    typedef struct packed {
        logic               transmit;
        logic               was_forced;
        logic [NORM_W-1:0]  norm_level;
        logic [COUNT_W-1:0] sent_count;
        logic [COUNT_W-1:0] held_count;
    } sod_decision_t;

    class sod_scoreboard;
        logic [DELTA_W-1:0]         delta;
        logic [KIND_W-1:0]          kind;
        logic [GAP_W-1:0]           min_gap;
        logic signed [SAMPLE_W-1:0] ref_vec [VEC_LEN];
        logic signed [SAMPLE_W-1:0] pend_vec [VEC_LEN];
        logic [VEC_LEN-1:0]         rx_mask;
        longint unsigned            norm_acc;
        longint unsigned            held_norm;
        logic [TIME_W-1:0]          last_send;
        bit                         have_sent;
        logic [COUNT_W-1:0]         n_sent;
        logic [COUNT_W-1:0]         n_held;
        sod_decision_t              decisions_due [$];
        int                         errors;

        function new();
            delta     = DELTA_RESET;
            kind      = KIND_RESET;
            min_gap   = GAP_RESET;
            foreach (ref_vec[i]) begin
                ref_vec[i]  = '0;
                pend_vec[i] = '0;
            end
            rx_mask   = '0;
            norm_acc  = 0;
            held_norm = 0;
            last_send = '0;
            have_sent = 1'b0;
            n_sent    = '0;
            n_held    = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_DELTA: delta   = val[DELTA_W-1:0];
                CFG_KIND:  kind    = val[KIND_W-1:0];
                CFG_GAP:   min_gap = val[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned norm_sat(longint unsigned v);
            return (v > NORM_CAP) ? NORM_CAP : v;
        endfunction

        function int due_count();
            return decisions_due.size();
        endfunction

        function void note_input(sod_comp_t c);
            longint          diff;
            longint unsigned mag;
            longint unsigned limit;
            logic [TIME_W-1:0] elapsed;
            bit              send;
            sod_decision_t   d;

            if (c.element_index < VEC_LEN) begin
                diff = longint'($signed(c.sample)) - longint'(ref_vec[c.element_index]);
                mag  = (diff < 0) ? -diff : diff;
                pend_vec[c.element_index] = c.sample;
                rx_mask[c.element_index]  = 1'b1;
                case (kind)
                    NORM_L1: norm_acc = norm_sat(norm_acc + mag);
                    NORM_L2: norm_acc = norm_sat(norm_acc + mag * mag);
                    default: if (mag > norm_acc) norm_acc = mag;
                endcase
            end
            if (!c.last_element) return;

            elapsed = c.timestamp - last_send;
            if (c.force_req) begin
                send = 1'b1;
            end else if (have_sent && elapsed < min_gap) begin
                // too soon after the previous send, norm not looked at
                send = 1'b0;
            end else begin
                limit     = (kind == NORM_L2) ? 64'(delta) * 64'(delta) : 64'(delta);
                held_norm = norm_acc;
                send      = norm_acc > limit;
            end

            if (send) begin
                // only the components seen since the last decision move
                foreach (ref_vec[i])
                    if (rx_mask[i]) ref_vec[i] = pend_vec[i];
                if (n_sent != COUNT_CAP) n_sent++;
                last_send = c.timestamp;
                have_sent = 1'b1;
            end else begin
                if (n_held != COUNT_CAP) n_held++;
            end
            rx_mask  = '0;
            norm_acc = 0;

            d.transmit   = send;
            d.was_forced = send && c.force_req;
            d.norm_level = held_norm[NORM_W-1:0];
            d.sent_count = n_sent;
            d.held_count = n_held;
            decisions_due.push_back(d);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t mismatch on %s: expected %0d actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(sod_decision_t got);
            sod_decision_t want;
            if (decisions_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t unexpected decision: expected none actual transmit %0d norm %0d",
                             $time, got.transmit, got.norm_level);
                return;
            end
            want = decisions_due.pop_front();
            compare_field("transmit", want.transmit, got.transmit);
            compare_field("was_forced", want.was_forced, got.was_forced);
            compare_field("norm_level", want.norm_level, got.norm_level);
            compare_field("sent_count", want.sent_count, got.sent_count);
            compare_field("held_count", want.held_count, got.held_count);
        endfunction
    endclass

endpackage

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import sod_pkg::*;
    import sod_tb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 235;
    localparam int SETTLE_CYCLES   = 8;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_HALF, RX_CHOKED} rx_mode_e;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    sod_in_if  in_if ();
    sod_out_if out_if ();

    send_on_delta_trigger dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    sod_scoreboard sb = new();

    bit                want_hold;
    bit                holding;
    int                burst_left;
    int                stall_cycles;
    int                phase_items;
    logic [TIME_W-1:0] now_ticks;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result({out_if.transmit, out_if.was_forced, out_if.norm_level,
                             out_if.sent_count, out_if.held_count});
    end

    // any stretch without a transfer on either side beyond the limit is a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : receiver
        rx_mode_e mode;
        int       run_len;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (want_hold) begin
                want_hold = 1'b0;
                holding   = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                holding = 1'b0;
            end
            mode    = rx_mode_e'($urandom_range(0, 3));
            run_len = $urandom_range(1, 40);
            repeat (run_len) begin
                case (mode)
                    RX_OPEN:   out_if.ready <= 1'b1;
                    RX_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:   out_if.ready <= ($urandom_range(0, 1) != 0);
                    default:   out_if.ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    function automatic sod_comp_t mk_comp(input logic signed [SAMPLE_W-1:0] s, input int idx,
                                          input bit is_last, input logic [TIME_W-1:0] ts,
                                          input bit frc);
        sod_comp_t c;
        c.sample        = s;
        c.element_index = IDX_BITS'(idx);
        c.last_element  = is_last;
        c.timestamp     = ts;
        c.force_req     = frc;
        return c;
    endfunction

    // one transfer, then maybe a gap when the burst runs out
    task automatic push_comp(input sod_comp_t c);
        int gap;
        in_if.valid         <= 1'b1;
        in_if.sample        <= c.sample;
        in_if.element_index <= c.element_index;
        in_if.last_element  <= c.last_element;
        in_if.timestamp     <= c.timestamp;
        in_if.force_req     <= c.force_req;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(c);
        phase_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else if (!holding) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // block is idle once every decision is back and the pipe has flushed
    task automatic drain_block();
        in_if.valid <= 1'b0;
        while (sb.due_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves the write enable high, the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic send_vector(input int amp);
        logic [IDX_BITS-1:0] slot [12];
        logic [IDX_BITS-1:0] tmp;
        int                  shape;
        int                  n_comp;
        int                  off;
        int                  k;
        int                  j;
        bit                  is_last;
        logic [TIME_W-1:0]   ts;

        shape = $urandom_range(0, 9);
        if (shape < 6)      n_comp = VEC_LEN;
        else if (shape < 9) n_comp = $urandom_range(1, VEC_LEN);
        else                n_comp = $urandom_range(2, 12);

        for (k = 0; k < VEC_LEN; k++) slot[k] = IDX_BITS'(k);
        if (shape >= 5 && shape < 9) begin
            for (k = VEC_LEN - 1; k > 0; k--) begin
                j       = $urandom_range(0, k);
                tmp     = slot[k];
                slot[k] = slot[j];
                slot[j] = tmp;
            end
        end
        if (shape == 9) begin
            // indices may repeat
            for (k = 0; k < n_comp; k++) slot[k] = IDX_BITS'($urandom_range(0, VEC_LEN - 1));
        end

        case ($urandom_range(0, 7))
            0:       now_ticks = $urandom();
            1:       now_ticks = now_ticks + $urandom_range(0, 50);
            default: now_ticks = now_ticks + $urandom_range(0, 3000);
        endcase

        for (k = 0; k < n_comp; k++) begin
            off     = int'($urandom_range(0, 2 * amp)) - amp;
            is_last = (k == n_comp - 1);
            ts      = (is_last || $urandom_range(0, 1)) ? now_ticks : TIME_W'($urandom());
            push_comp(mk_comp(SAMPLE_W'(sb.ref_vec[slot[k]] + off), slot[k], is_last, ts,
                              is_last ? ($urandom_range(0, 7) == 0)
                                      : ($urandom_range(0, 1) != 0)));
        end
    endtask

    task automatic run_phase(input logic [DELTA_W-1:0] delta, input logic [KIND_W-1:0] kind,
                             input logic [GAP_W-1:0] gap);
        int amp;
        drain_block();
        write_reg(CFG_DELTA, CFG_W'(delta));
        write_reg(CFG_KIND, CFG_W'(kind));
        write_reg(CFG_GAP, CFG_W'(gap));
        i_cfg_we <= 1'b0;
        phase_items = 0;
        while (phase_items < PHASE_ITEMS) begin
            case ($urandom_range(0, 4))
                0:       amp = delta / 8;
                1:       amp = delta / 2;
                2:       amp = delta;
                3:       amp = 2 * delta;
                default: amp = 65535;
            endcase
            if (amp < 1) amp = 1;
            if (amp > 65535) amp = 65535;
            send_vector(amp);
        end
    endtask

    task automatic directed_part();
        int k;
        // nothing sent yet, so a quick first vector is judged on its norm
        push_comp(mk_comp(16'sh7FFF, 3, 1'b1, 32'd5, 1'b0));
        // forced full vector at the negative extreme, just ahead of the time wrap
        for (k = 0; k < VEC_LEN; k++)
            push_comp(mk_comp(16'sh8000, k, k == VEC_LEN - 1, 32'hFFFF_FFF0, k == VEC_LEN - 1));
        drain_block();
        write_reg(CFG_KIND, CFG_W'(NORM_L2));
        i_cfg_we <= 1'b0;
        // widest differences plus a repeated index push the squared norm to its cap
        for (k = 0; k < VEC_LEN; k++)
            push_comp(mk_comp(16'sh7FFF, k, 1'b0, 32'h0000_03F0, 1'b0));
        push_comp(mk_comp(16'sh7FFF, 0, 1'b1, 32'h0000_03F0, 1'b0));
        // norm kind switched between two components of one vector
        push_comp(mk_comp(16'sh0000, 0, 1'b0, 32'h0000_0000, 1'b1));
        drain_block();
        write_reg(CFG_KIND, CFG_W'(NORM_L1));
        i_cfg_we <= 1'b0;
        push_comp(mk_comp(-16'sd1, 1, 1'b1, 32'h0000_0400, 1'b0));
        push_comp(mk_comp(16'sh0000, 5, 1'b1, 32'hFFFF_FFFF, 1'b0));
    endtask

    initial begin : main_seq
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= '0;
        i_cfg_data          <= '0;
        in_if.valid         <= 1'b0;
        in_if.sample        <= '0;
        in_if.element_index <= '0;
        in_if.last_element  <= 1'b0;
        in_if.timestamp     <= '0;
        in_if.force_req     <= 1'b0;
        now_ticks  = '0;
        burst_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_part();
        run_phase(19'd1, NORM_CHEB, 32'd0);
        // long receiver hold-off while this phase keeps offering transfers
        drain_block();
        want_hold = 1'b1;
        run_phase(19'd524280, NORM_L1, 32'd1000);
        run_phase(19'd300, NORM_L2, 32'hFFFF_FFFF);
        run_phase(19'd1000, NORM_L1, 32'd500);
        run_phase(19'd256, NORM_SPARE, 32'd2000);
        run_phase(DELTA_W'($urandom_range(1, 524280)), NORM_L2, 32'd0);
        run_phase(19'd40, NORM_CHEB, GAP_W'($urandom_range(0, 3000)));
        run_phase(DELTA_W'($urandom_range(1, 5000)), KIND_W'($urandom_range(0, 3)),
                  GAP_W'($urandom_range(0, 3000)));
        drain_block();

        if (sb.errors == 0 && sb.due_count() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
